@@ hw/rtl/broadcast_step_schedule_macros.svh @@
// Assertion macros shared by the broadcast step schedule RTL.
`ifndef BROADCAST_STEP_SCHEDULE_MACROS_SVH
`define BROADCAST_STEP_SCHEDULE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BSS_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bss: same-cycle check failed");

// Next-cycle implication, checked out of reset.
`define BSS_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bss: next-cycle check failed");

`endif

@@ hw/rtl/bss_pkg.sv @@
// Shared constants, register codes and helpers of the broadcast step schedule.
package bss_pkg;

    localparam int MaxRanks  = 64;
    localparam int MaxSlices = 32;

    localparam int RankW    = $clog2(MaxRanks + 1);
    localparam int IdxW     = $clog2(MaxRanks);
    localparam int StepW    = 4;
    localparam int PscW     = 3;
    localparam int CntW     = 6;
    localparam int NumW     = 5;
    localparam int CfgIdxW  = 3;
    localparam int CfgDataW = 7;

    // Configuration register indexes
    localparam logic [CfgIdxW-1:0] CFG_RANK_COUNT  = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_MY_INDEX    = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_ROOT_INDEX  = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_PHASE_STEPS = 3'd3;

    typedef logic [RankW-1:0] t_rank;
    typedef logic [IdxW-1:0]  t_idx;

    // Clamp the programmed rank count into 1 .. MaxRanks.
    function automatic t_rank eff_ranks(input t_rank cfg);
        t_rank res;
        if (cfg == '0) begin
            res = t_rank'(1);
        end else if (cfg > t_rank'(MaxRanks)) begin
            res = t_rank'(MaxRanks);
        end else begin
            res = cfg;
        end
        return res;
    endfunction

endpackage

@@ hw/rtl/broadcast_step_schedule.sv @@
// Broadcast step schedule: one step number in, one item per slice out (one item when the step has no work).
// The first result item is offered after the remainder walks, the four ops and S_DECIDE.
// Results: n items per step, one per cycle unless the result channel stalls; no new step until the last is taken.
// Step time set by one shared compare-subtract unit: three remainders of 7-bit values, four ops.
// Reset (i_rst_n low, synchronous): rank_count = 1, other config registers 0, idle; datapath registers not reset.
`include "broadcast_step_schedule_macros.svh"

module broadcast_step_schedule (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // configuration write channel
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [bss_pkg::CfgIdxW-1:0]  i_cfg_index,
    input  logic [bss_pkg::CfgDataW-1:0] i_cfg_data,
    // step input channel
    input  logic                         i_in_valid,
    output logic                         o_in_ready,
    input  logic [bss_pkg::StepW-1:0]    i_step_index,
    // result channel
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic                         o_phase,
    output logic                         o_step_valid,
    output logic                         o_sends,
    output logic [bss_pkg::IdxW-1:0]     o_send_peer,
    output logic                         o_receives,
    output logic [bss_pkg::IdxW-1:0]     o_recv_peer,
    output logic [bss_pkg::CntW-1:0]     o_slice_count,
    output logic [bss_pkg::NumW-1:0]     o_slice_number,
    output logic [bss_pkg::IdxW-1:0]     o_tx_slice,
    output logic [bss_pkg::IdxW-1:0]     o_rx_slice,
    output logic                         o_last
);
    import bss_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_MODME  = 4'd1;  // my_index mod ranks
    localparam logic [3:0] S_MODRT  = 4'd2;  // root_index mod ranks
    localparam logic [3:0] S_MODD   = 4'd3;  // distance mod ranks
    localparam logic [3:0] S_DROOT  = 4'd4;  // distance from me to root
    localparam logic [3:0] S_SMOD   = 4'd5;  // stride mod ranks
    localparam logic [3:0] S_SUB    = 4'd6;  // me - distance
    localparam logic [3:0] S_ADD    = 4'd7;  // me + distance
    localparam logic [3:0] S_DECIDE = 4'd8;
    localparam logic [3:0] S_EMIT   = 4'd9;

    localparam logic [2:0] TopBit = 3'(RankW - 1);

    // Configuration registers
    t_rank            r_rank_cfg;
    t_idx             r_my_cfg;
    t_idx             r_root_cfg;
    logic [PscW-1:0]  r_psc;

    // Control
    logic [3:0]       r_state, n_state;
    logic [2:0]       r_bit;
    logic             r_out_valid;

    // Working values
    logic [StepW-1:0] r_step;
    t_idx             r_rem;
    t_idx             r_me, r_root, r_dm, r_droot, r_sm, r_msub, r_madd;

    // Result registers
    logic             r_ph, r_vld, r_snd, r_rcv, r_last;
    t_idx             r_sp, r_rp, r_tx, r_rx;
    logic [CntW-1:0]  r_cnt;
    logic [NumW-1:0]  r_num;

    // Step decode from the held step and the configuration
    t_rank            rk;
    logic [4:0]       two_p;
    logic             st_valid, st_ph;
    logic [2:0]       e;
    t_rank            d;

    assign rk       = eff_ranks(r_rank_cfg);
    assign two_p    = {1'b0, r_psc, 1'b0};
    assign st_valid = {1'b0, r_step} < two_p;
    assign st_ph    = r_step >= {1'b0, r_psc};

    always_comb begin
        logic [4:0] e_ag;
        e_ag = two_p - 5'd1 - {1'b0, r_step};
        e    = st_ph ? e_ag[2:0] : r_step[2:0];
        d    = t_rank'(1) << e;
    end

    // Shared compare-subtract unit: res = x >= y ? x - y : x
    logic [7:0] unit_x, unit_y, unit_res;
    logic [RankW-1:0] mod_src;

    assign unit_y = {1'b0, rk};

    always_comb begin
        unique case (r_state)
            S_MODME: mod_src = {1'b0, r_my_cfg};
            S_MODRT: mod_src = {1'b0, r_root_cfg};
            default: mod_src = d;
        endcase
    end

    always_comb begin
        unique case (r_state)
            S_MODME, S_MODRT, S_MODD:
                unit_x = {1'b0, r_rem, mod_src[r_bit]};
            S_DROOT: unit_x = {2'b0, r_root} + {1'b0, rk} - {2'b0, r_me};
            S_SMOD:  unit_x = {1'b0, r_dm, 1'b0};
            S_SUB:   unit_x = {2'b0, r_me} + {1'b0, rk} - {2'b0, r_dm};
            S_ADD:   unit_x = {2'b0, r_me} + {2'b0, r_dm};
            default: unit_x = '0;
        endcase
    end

    assign unit_res = (unit_x >= unit_y) ? (unit_x - unit_y) : unit_x;

    // Step decision, used in S_DECIDE
    logic       perfect, trim, dc_snd, dc_rcv, dc_idle;
    t_rank      nranks;
    logic [7:0] nsl_sum, nsl_raw;
    logic [3:0] sh;
    logic [CntW-1:0] nsl_sat;
    t_idx       dc_sp, dc_rp, dc_tx, dc_rx;

    always_comb begin
        perfect = (rk & (rk - t_rank'(1))) == '0;
        trim    = !perfect && (r_step == ({1'b0, r_psc} - 4'd1));
        if (trim) begin
            nranks = (d < rk) ? (rk - d) : '0;
        end else begin
            nranks = d;
        end
        nsl_sum = {1'b0, rk} - 8'd1 + {1'b0, d};
        sh      = {1'b0, e} + 4'd1;
        nsl_raw = nsl_sum >> sh;
        nsl_sat = (nsl_raw > 8'(MaxSlices)) ? CntW'(MaxSlices) : nsl_raw[CntW-1:0];

        dc_snd = 1'b0;
        dc_rcv = 1'b0;
        dc_sp  = '0;
        dc_rp  = '0;
        dc_tx  = '0;
        dc_rx  = '0;
        if (st_valid) begin
            if (!st_ph) begin
                if ({1'b0, r_droot} < nranks) begin
                    dc_snd = 1'b1;
                    dc_sp  = r_msub;
                    dc_tx  = r_msub;
                end else if ({1'b0, r_droot} >= d &&
                             {2'b0, r_droot} < ({1'b0, nranks} + {1'b0, d})) begin
                    dc_rcv = 1'b1;
                    dc_rp  = r_madd;
                    dc_rx  = r_me;
                end
            end else begin
                dc_snd = 1'b1;
                dc_rcv = 1'b1;
                dc_sp  = r_madd;
                dc_rp  = r_msub;
                dc_tx  = r_me;
                dc_rx  = r_msub;
            end
        end
        dc_idle = !st_valid || nsl_raw == '0 || (!dc_snd && !dc_rcv);
    end

    // Slice lanes: step tx and rx down by the stride, modulo the rank count
    t_idx tx_step, rx_step;

    always_comb begin
        if ({1'b0, r_tx} >= {1'b0, r_sm}) begin
            tx_step = r_tx - r_sm;
        end else begin
            tx_step = IdxW'({1'b0, r_tx} + rk - {1'b0, r_sm});
        end
        if ({1'b0, r_rx} >= {1'b0, r_sm}) begin
            rx_step = r_rx - r_sm;
        end else begin
            rx_step = IdxW'({1'b0, r_rx} + rk - {1'b0, r_sm});
        end
    end

    // Handshakes: hold both input channels off while reset is applied or the sequencer is not idle
    logic in_acc, out_acc, cfg_acc;

    assign o_in_ready  = i_rst_n && (r_state == S_IDLE);
    assign o_cfg_ready = i_rst_n && (r_state == S_IDLE);
    assign in_acc      = i_in_valid && o_in_ready;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign out_acc     = r_out_valid && i_out_ready;

    // Sequencer: walk the remainder bits, then the single-step ops, the decision and the emit
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (in_acc) n_state = S_MODME;
            S_MODME:  if (r_bit == '0) n_state = S_MODRT;
            S_MODRT:  if (r_bit == '0) n_state = S_MODD;
            S_MODD:   if (r_bit == '0) n_state = S_DROOT;
            S_DROOT:  n_state = S_SMOD;
            S_SMOD:   n_state = S_SUB;
            S_SUB:    n_state = S_ADD;
            S_ADD:    n_state = S_DECIDE;
            S_DECIDE: n_state = S_EMIT;
            S_EMIT:   if (out_acc && r_last) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_bit       <= TopBit;
            r_out_valid <= 1'b0;
            r_rank_cfg  <= t_rank'(1);
            r_my_cfg    <= '0;
            r_root_cfg  <= '0;
            r_psc       <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_MODME || r_state == S_MODRT || r_state == S_MODD) begin
                r_bit <= (r_bit == '0) ? TopBit : r_bit - 3'd1;
            end
            if (r_state == S_DECIDE) begin
                r_out_valid <= 1'b1;
            end else if (out_acc && r_last) begin
                r_out_valid <= 1'b0;
            end
            if (cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_RANK_COUNT:  r_rank_cfg <= i_cfg_data[RankW-1:0];
                    CFG_MY_INDEX:    r_my_cfg   <= i_cfg_data[IdxW-1:0];
                    CFG_ROOT_INDEX:  r_root_cfg <= i_cfg_data[IdxW-1:0];
                    CFG_PHASE_STEPS: r_psc      <= i_cfg_data[PscW-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_step <= i_step_index;
            r_rem  <= '0;
        end
        unique case (r_state)
            S_MODME, S_MODRT, S_MODD: begin
                // hold the partial remainder, clear it when the word is done
                r_rem <= (r_bit == '0) ? '0 : unit_res[IdxW-1:0];
                if (r_bit == '0) begin
                    if (r_state == S_MODME) r_me   <= unit_res[IdxW-1:0];
                    if (r_state == S_MODRT) r_root <= unit_res[IdxW-1:0];
                    if (r_state == S_MODD)  r_dm   <= unit_res[IdxW-1:0];
                end
            end
            S_DROOT: r_droot <= unit_res[IdxW-1:0];
            S_SMOD:  r_sm    <= unit_res[IdxW-1:0];
            S_SUB:   r_msub  <= unit_res[IdxW-1:0];
            S_ADD:   r_madd  <= unit_res[IdxW-1:0];
            S_DECIDE: begin
                r_ph  <= st_ph;
                r_vld <= st_valid;
                r_num <= '0;
                if (dc_idle) begin
                    r_snd  <= 1'b0;
                    r_rcv  <= 1'b0;
                    r_sp   <= '0;
                    r_rp   <= '0;
                    r_cnt  <= '0;
                    r_tx   <= '0;
                    r_rx   <= '0;
                    r_last <= 1'b1;
                end else begin
                    r_snd  <= dc_snd;
                    r_rcv  <= dc_rcv;
                    r_sp   <= dc_sp;
                    r_rp   <= dc_rp;
                    r_cnt  <= nsl_sat;
                    r_tx   <= dc_tx;
                    r_rx   <= dc_rx;
                    r_last <= nsl_sat == CntW'(1);
                end
            end
            S_EMIT: begin
                // advance to the next slice once the current item is taken
                if (out_acc && !r_last) begin
                    r_num  <= r_num + NumW'(1);
                    r_tx   <= tx_step;
                    r_rx   <= rx_step;
                    r_last <= ({1'b0, r_num} + CntW'(2)) == r_cnt;
                end
            end
            default: ;
        endcase
    end

    // Outputs
    assign o_out_valid    = r_out_valid;
    assign o_phase        = r_ph;
    assign o_step_valid   = r_vld;
    assign o_sends        = r_snd;
    assign o_send_peer    = r_sp;
    assign o_receives     = r_rcv;
    assign o_recv_peer    = r_rp;
    assign o_slice_count  = r_cnt;
    assign o_slice_number = r_num;
    assign o_tx_slice     = r_snd ? r_tx : '0;
    assign o_rx_slice     = r_rcv ? r_rx : '0;
    assign o_last         = r_last;

    // Assertions
    `BSS_IMPLIES(a_out_in_emit, r_out_valid, r_state == S_EMIT)
    `BSS_IMPLIES(a_last_matches_count, r_out_valid && r_last, (r_cnt == '0) || (({1'b0, r_num} + CntW'(1)) == r_cnt))
    `BSS_NEXT(a_slice_advances, out_acc && !r_last, r_out_valid && (r_num == $past(r_num) + NumW'(1)))
    `BSS_IMPLIES(a_tx_in_range, r_out_valid, {1'b0, o_tx_slice} < rk && {1'b0, o_rx_slice} < rk)
    `BSS_IMPLIES(a_no_overlap, o_in_ready, !r_out_valid)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the broadcast step schedule: predicted slice items vs DUT.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import bss_pkg::*;

    // One expected result item, at the widths of the result ports.
    typedef struct packed {
        logic            phase;
        logic            step_valid;
        logic            sends;
        logic [IdxW-1:0] send_peer;
        logic            receives;
        logic [IdxW-1:0] recv_peer;
        logic [CntW-1:0] slice_count;
        logic [NumW-1:0] slice_number;
        logic [IdxW-1:0] tx_slice;
        logic [IdxW-1:0] rx_slice;
        logic            last;
    } t_slice;

    // Register indexes the block ignores.
    localparam logic [CfgIdxW-1:0] CfgSpareLo = CFG_PHASE_STEPS + 1'b1;
    localparam logic [CfgIdxW-1:0] CfgSpareHi = {CfgIdxW{1'b1}};

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_cfg_valid;
    logic                o_cfg_ready;
    logic [CfgIdxW-1:0]  i_cfg_index;
    logic [CfgDataW-1:0] i_cfg_data;
    logic                i_in_valid;
    logic                o_in_ready;
    logic [StepW-1:0]    i_step_index;
    logic                o_out_valid;
    logic                i_out_ready;
    logic                o_phase;
    logic                o_step_valid;
    logic                o_sends;
    logic [IdxW-1:0]     o_send_peer;
    logic                o_receives;
    logic [IdxW-1:0]     o_recv_peer;
    logic [CntW-1:0]     o_slice_count;
    logic [NumW-1:0]     o_slice_number;
    logic [IdxW-1:0]     o_tx_slice;
    logic [IdxW-1:0]     o_rx_slice;
    logic                o_last;

    // Shadow copy of the configuration, at reset values.
    logic [RankW-1:0] cfg_ranks = 7'd1;
    logic [IdxW-1:0]  cfg_me    = '0;
    logic [IdxW-1:0]  cfg_root  = '0;
    logic [PscW-1:0]  cfg_steps = '0;

    t_slice      pending_slices[$];
    int unsigned mismatches  = 0;
    int unsigned in_gap_max  = 9;
    int unsigned out_gap_max = 9;

    broadcast_step_schedule dut (.*);

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // (a - d) mod r on the ring of r ranks
    function automatic int unsigned ring_back(input int unsigned a, input int unsigned d,
                                              input int unsigned r);
        return (a + r - (d % r)) % r;
    endfunction

    // Work out every slice item that one accepted step causes and queue them.
    function automatic void schedule_step(input logic [StepW-1:0] step);
        int unsigned st, p, r, me, root, span, reach, droot, nsl, stride, sp, rp, tx, rx;
        logic        ph, ok, snd, rcv;
        t_slice      item;
        st = step;
        p  = cfg_steps;
        r  = cfg_ranks;
        if (r == 0) r = 1;
        if (r > MaxRanks) r = MaxRanks;
        me     = cfg_me % r;
        root   = cfg_root % r;
        ok     = st < 2 * p;
        ph     = st >= p;
        snd    = 1'b0;
        rcv    = 1'b0;
        sp     = 0;
        rp     = 0;
        tx     = 0;
        rx     = 0;
        nsl    = 0;
        stride = 1;
        if (ok) begin
            if (!ph) begin
                // scatter: distance doubles as the step grows
                span   = 32'd1 << st;
                reach  = span;
                droot  = (root + r - me) % r;
                nsl    = (r - 1 + span) / (span * 2);
                stride = span * 2;
                // trim the last scatter step on a non-power-of-two ring
                if ((r & (r - 1)) != 0 && st == p - 1)
                    reach = (span < r) ? r - span : 0;
                if (droot < reach) begin
                    snd = 1'b1;
                    sp  = ring_back(me, span, r);
                    tx  = sp;
                end else if (droot >= span && droot < reach + span) begin
                    rcv = 1'b1;
                    rp  = (me + span) % r;
                    rx  = me;
                end
            end else begin
                // all-gather: distances run back down, send and receive together
                span   = 32'd1 << (p - 1 - (st - p));
                nsl    = (r - 1 + span) / (span * 2);
                stride = span * 2;
                snd    = 1'b1;
                rcv    = 1'b1;
                sp     = (me + span) % r;
                rp     = ring_back(me, span, r);
                tx     = me;
                rx     = rp;
            end
        end

        item            = '0;
        item.phase      = ph;
        item.step_valid = ok;
        if (nsl == 0 || (!snd && !rcv)) begin
            item.last = 1'b1;
            pending_slices = {pending_slices, item};
        end else begin
            if (nsl > MaxSlices) nsl = MaxSlices;
            item.sends       = snd;
            item.send_peer   = IdxW'(sp);
            item.receives    = rcv;
            item.recv_peer   = IdxW'(rp);
            item.slice_count = CntW'(nsl);
            for (int unsigned i = 0; i < nsl; i++) begin
                item.slice_number = NumW'(i);
                item.tx_slice     = snd ? IdxW'(tx) : '0;
                item.rx_slice     = rcv ? IdxW'(rx) : '0;
                item.last         = (i + 1 == nsl);
                pending_slices = {pending_slices, item};
                tx = ring_back(tx, stride, r);
                rx = ring_back(rx, stride, r);
            end
        end
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Compare every accepted result item with the oldest prediction.
    always @(posedge i_clk) begin : result_check
        t_slice want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_slices.size() == 0) begin
                $error("result item with nothing pending");
                mismatches++;
            end else begin
                want = pending_slices.pop_front();
                check_field("phase",        want.phase,        o_phase);
                check_field("step_valid",   want.step_valid,   o_step_valid);
                check_field("sends",        want.sends,        o_sends);
                check_field("send_peer",    want.send_peer,    o_send_peer);
                check_field("receives",     want.receives,     o_receives);
                check_field("recv_peer",    want.recv_peer,    o_recv_peer);
                check_field("slice_count",  want.slice_count,  o_slice_count);
                check_field("slice_number", want.slice_number, o_slice_number);
                check_field("tx_slice",     want.tx_slice,     o_tx_slice);
                check_field("rx_slice",     want.rx_slice,     o_rx_slice);
                check_field("last",         want.last,         o_last);
            end
        end
    end

    // Result side: hold off ready for a drawn number of cycles per item, then
    // keep it high until the item is taken.
    initial begin : result_sink
        int unsigned gap;
        i_out_ready = 1'b0;
        forever begin
            gap = $urandom_range(0, out_gap_max);
            repeat (gap) begin
                @(negedge i_clk);
                i_out_ready <= 1'b0;
            end
            @(negedge i_clk);
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (!(o_out_valid && i_out_ready));
        end
    end

    // Offer one step after a drawn gap; predict its slices once accepted.
    // Valid is left high so a back-to-back item never lowers it in between.
    task automatic send_step(input logic [StepW-1:0] step);
        int unsigned gap;
        gap = $urandom_range(0, in_gap_max);
        @(negedge i_clk);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_step_index <= step;
        do @(posedge i_clk); while (!(i_in_valid && o_in_ready));
        schedule_step(step);
    endtask

    // Drop valid, wait for every pending item, then let the block go quiet.
    task automatic settle();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_slices.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    // One register write; the shadow copy follows on acceptance.
    task automatic write_reg(input logic [CfgIdxW-1:0] idx, input int unsigned value);
        logic [CfgDataW-1:0] data;
        data = CfgDataW'(value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!(i_cfg_valid && o_cfg_ready));
        case (idx)
            CFG_RANK_COUNT:  cfg_ranks = data[RankW-1:0];
            CFG_MY_INDEX:    cfg_me    = data[IdxW-1:0];
            CFG_ROOT_INDEX:  cfg_root  = data[IdxW-1:0];
            CFG_PHASE_STEPS: cfg_steps = data[PscW-1:0];
            default: ;
        endcase
    endtask

    // Program the whole schedule; a write to a spare index goes first and must
    // change nothing.
    task automatic program_regs(input int unsigned ranks, input int unsigned me,
                                input int unsigned root, input int unsigned steps);
        write_reg(CfgIdxW'($urandom_range(CfgSpareLo, CfgSpareHi)),
                  $urandom_range(0, (1 << CfgDataW) - 1));
        write_reg(CFG_RANK_COUNT, ranks);
        write_reg(CFG_MY_INDEX, me);
        write_reg(CFG_ROOT_INDEX, root);
        write_reg(CFG_PHASE_STEPS, steps);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Out of reset there are no phase steps, so every step is out of range.
    task automatic test_reset_state();
        send_step(4'd0);
        send_step(4'd15);
        settle();
    endtask

    // Eight ranks: full scatter, full all-gather, then one step past the end.
    task automatic test_power_of_two_walk();
        program_regs(8, 3, 5, 3);
        for (int s = 0; s <= 6; s++) send_step(StepW'(s));
        settle();
    endtask

    // Trimmed last scatter step, trim distance past the ring, stride past the ring.
    task automatic test_trimmed_ring();
        program_regs(5, 4, 1, 3);
        send_step(4'd2);
        send_step(4'd3);
        settle();
        program_regs(3, 2, 0, 3);
        send_step(4'd2);
        send_step(4'd4);
        settle();
    endtask

    // Largest ring, rank count of zero, rank count over the maximum, indexes
    // beyond the ring and the widest phase step count.
    task automatic test_extreme_config();
        program_regs(64, 63, 0, 6);
        send_step(4'd0);
        send_step(4'd11);
        send_step(4'd12);
        send_step(4'd15);
        settle();
        program_regs(0, 127, 127, 7);
        send_step(4'd0);
        send_step(4'd13);
        settle();
        program_regs(127, 64, 127, 7);
        send_step(4'd6);
        send_step(4'd7);
        send_step(4'd13);
        settle();
    endtask

    // Mostly whole schedules on a matching step count, with stray steps and
    // odd configurations mixed in; some groups run with no hold-off on the input or the result side.
    task automatic test_random_schedules();
        int unsigned sent, group, ranks, eff, steps, me, root;
        sent  = 0;
        group = 0;
        while (sent < 80) begin
            case ($urandom_range(0, 5))
                0:       ranks = $urandom_range(0, 1) ? 0 : $urandom_range(65, 127);
                1:       ranks = 64;
                default: ranks = $urandom_range(1, 64);
            endcase
            eff = (ranks == 0) ? 1 : (ranks > MaxRanks ? MaxRanks : ranks);
            steps = 0;
            while ((1 << steps) < eff) steps++;
            if ($urandom_range(0, 4) == 0) steps = $urandom_range(0, 7);
            me   = $urandom_range(0, 2) == 0 ? $urandom_range(0, 127) : $urandom_range(0, eff - 1);
            root = $urandom_range(0, 2) == 0 ? $urandom_range(0, 127) : $urandom_range(0, eff - 1);
            in_gap_max  = (group % 4 == 3) ? 0 : 9;
            out_gap_max = (group % 3 == 2) ? 0 : 9;
            program_regs(ranks, me, root, steps);
            // walk the schedule in order, then a couple of arbitrary steps
            for (int s = 0; s < 2 * steps; s++) send_step(StepW'(s));
            repeat (2) send_step(StepW'($urandom_range(0, 15)));
            sent += 2 * steps + 2;
            group++;
            settle();
        end
        in_gap_max  = 9;
        out_gap_max = 9;
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        i_in_valid   = 1'b0;
        i_step_index = '0;
        // hold reset, release on a falling edge
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_power_of_two_walk();
        test_trimmed_ring();
        test_extreme_config();
        test_random_schedules();
        settle();

        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run.
    initial begin
        #5_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/bss_pkg.sv
hw/rtl/broadcast_step_schedule.sv
tb/tb_top.sv
